/* rtl/core/cep_pkg.sv */
// Shared types, constants and field tables for the cron expression parser.
package cep_pkg;

    localparam logic [2:0]  NUM_FIELDS = 3'd5;
    localparam logic [2:0]  COUNT_SAT  = 3'd6;
    localparam logic [13:0] BIG_LIMIT  = 14'd1000;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_COUNT  = 3'd1;
    localparam logic [2:0] ST_SYNTAX = 3'd2;
    localparam logic [2:0] ST_VALUE  = 3'd3;
    localparam logic [2:0] ST_STEP   = 3'd4;

    localparam logic [2:0] FLD_MINUTE  = 3'd0;
    localparam logic [2:0] FLD_HOUR    = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_MONTH   = 3'd3;
    localparam logic [2:0] FLD_WEEKDAY = 3'd4;

    typedef enum logic [2:0] {
        FORM_START,
        FORM_STAR,
        FORM_SLASH,
        FORM_STEP,
        FORM_NUMBER,
        FORM_BAD
    } form_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_EXPAND,
        CTRL_EXPAND_END,
        CTRL_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] character;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [59:0] minute_mask;
        logic [23:0] hour_mask;
        logic [31:0] day_mask;
        logic [12:0] month_mask;
        logic [6:0]  weekday_mask;
    } res_t;

    typedef struct packed {
        logic take_byte;
        logic take_end;
        logic expand;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_expand;
        logic expand_last;
    } dp_stat_t;

    function automatic logic [5:0] field_low(logic [2:0] f);
        logic [5:0] r;
        unique case (f)
            FLD_DAY, FLD_MONTH: r = 6'd1;
            default:            r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] field_high(logic [2:0] f);
        logic [5:0] r;
        unique case (f)
            FLD_MINUTE:  r = 6'd59;
            FLD_HOUR:    r = 6'd23;
            FLD_DAY:     r = 6'd31;
            FLD_MONTH:   r = 6'd12;
            default:     r = 6'd6;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] field_size(logic [2:0] f);
        logic [5:0] r;
        unique case (f)
            FLD_MINUTE:  r = 6'd60;
            FLD_HOUR:    r = 6'd24;
            FLD_DAY:     r = 6'd31;
            FLD_MONTH:   r = 6'd12;
            default:     r = 6'd7;
        endcase
        return r;
    endfunction

    function automatic logic [59:0] star_mask(logic [2:0] f);
        logic [59:0] r;
        unique case (f)
            FLD_MINUTE:  r = {60{1'b1}};
            FLD_HOUR:    r = {36'd0, {24{1'b1}}};
            FLD_DAY:     r = {28'd0, {31{1'b1}}, 1'b0};
            FLD_MONTH:   r = {47'd0, {12{1'b1}}, 1'b0};
            default:     r = {53'd0, {7{1'b1}}};
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/cep_ctrl.sv */
// Controller state machine: request handshakes, step expansion sequencing, result emit.
module cep_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_command,
    output logic                req_ready,
    output logic                res_valid,
    input  logic                res_ready,
    input  cep_pkg::dp_stat_t   stat,
    output cep_pkg::ctrl_cmd_t  cmd
);

    cep_pkg::ctrl_state_t state_reg, state_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cep_pkg::CTRL_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        req_ready     = (state_reg == cep_pkg::CTRL_IDLE) &&
                        (!req_command || !res_valid_reg || res_ready);
        accept        = req_valid && req_ready;
        cmd.take_byte = accept && !req_command;
        cmd.take_end  = accept && req_command;
        cmd.expand    = (state_reg == cep_pkg::CTRL_EXPAND) ||
                        (state_reg == cep_pkg::CTRL_EXPAND_END);
        cmd.emit      = (state_reg == cep_pkg::CTRL_EMIT);

        res_valid_next = res_valid_reg;
        if (cmd.emit)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            cep_pkg::CTRL_IDLE:
            begin
                if (cmd.take_end)
                    state_next = stat.start_expand ? cep_pkg::CTRL_EXPAND_END
                                                   : cep_pkg::CTRL_EMIT;
                else if (cmd.take_byte && stat.start_expand)
                    state_next = cep_pkg::CTRL_EXPAND;
            end
            cep_pkg::CTRL_EXPAND:
            begin
                if (stat.expand_last)
                    state_next = cep_pkg::CTRL_IDLE;
            end
            cep_pkg::CTRL_EXPAND_END:
            begin
                if (stat.expand_last)
                    state_next = cep_pkg::CTRL_EMIT;
            end
            cep_pkg::CTRL_EMIT:
            begin
                state_next = cep_pkg::CTRL_IDLE;
            end
            default:
            begin
                state_next = cep_pkg::CTRL_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;

    // result slot is always free when a result is loaded
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cep_pkg::CTRL_EMIT) |-> !res_valid_reg)
        else $error("result loaded over pending result");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cep_pkg::CTRL_EMIT) |=> (state_reg == cep_pkg::CTRL_IDLE) && res_valid_reg)
        else $error("emit did not present result");

    a_end_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_end |=> (state_reg == cep_pkg::CTRL_EXPAND_END) ||
                         (state_reg == cep_pkg::CTRL_EMIT))
        else $error("end request did not head toward emit");

endmodule

/* rtl/core/cep_dp.sv */
// Datapath: token decode, number accumulation, field sets, step expansion, result register.
module cep_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  cep_pkg::ctrl_cmd_t  cmd,
    input  cep_pkg::req_t       req,
    output cep_pkg::dp_stat_t   stat,
    output cep_pkg::res_t       res
);

    logic [2:0]     token_count_reg, token_count_next;
    logic           inside_reg, inside_next;
    cep_pkg::form_t form_reg, form_next;
    logic [13:0]    value_reg, value_next;
    logic           too_big_reg, too_big_next;
    logic [2:0]     first_error_reg, first_error_next;
    logic [59:0]    minute_set_reg, minute_set_next;
    logic [23:0]    hour_set_reg, hour_set_next;
    logic [31:0]    day_set_reg, day_set_next;
    logic [12:0]    month_set_reg, month_set_next;
    logic [6:0]     weekday_set_reg, weekday_set_next;
    logic [5:0]     v_reg, v_next;
    logic [5:0]     step_reg, step_next;
    logic [2:0]     xfield_reg, xfield_next;
    cep_pkg::res_t  res_reg, res_next;

    logic           is_space, is_digit, finish, field_ok, step_ok, num_ok, ok;
    logic [3:0]     digit;
    logic [13:0]    dig_value;
    logic           dig_big;
    logic [5:0]     lo, hi, size;
    logic [6:0]     v_sum;
    logic [59:0]    set_bits;
    logic [2:0]     set_field;
    logic           set_en;
    logic [2:0]     status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_count_reg <= '0;
            inside_reg      <= 1'b0;
            form_reg        <= cep_pkg::FORM_START;
            value_reg       <= '0;
            too_big_reg     <= 1'b0;
            first_error_reg <= cep_pkg::ST_OK;
            minute_set_reg  <= '0;
            hour_set_reg    <= '0;
            day_set_reg     <= '0;
            month_set_reg   <= '0;
            weekday_set_reg <= '0;
        end
        else
        begin
            token_count_reg <= token_count_next;
            inside_reg      <= inside_next;
            form_reg        <= form_next;
            value_reg       <= value_next;
            too_big_reg     <= too_big_next;
            first_error_reg <= first_error_next;
            minute_set_reg  <= minute_set_next;
            hour_set_reg    <= hour_set_next;
            day_set_reg     <= day_set_next;
            month_set_reg   <= month_set_next;
            weekday_set_reg <= weekday_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        step_reg   <= step_next;
        xfield_reg <= xfield_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        is_space = ((req.character >= 8'd9) && (req.character <= 8'd13)) ||
                   (req.character == 8'd32);
        is_digit = (req.character >= 8'h30) && (req.character <= 8'h39);
        digit    = req.character[3:0];

        dig_value = value_reg;
        dig_big   = too_big_reg;
        if (!too_big_reg)
        begin
            if (value_reg > cep_pkg::BIG_LIMIT)
                dig_big = 1'b1;
            else
                dig_value = (value_reg << 3) + (value_reg << 1) + {10'd0, digit};
        end

        field_ok = token_count_reg < cep_pkg::NUM_FIELDS;
        lo       = cep_pkg::field_low(token_count_reg);
        hi       = cep_pkg::field_high(token_count_reg);
        size     = cep_pkg::field_size(token_count_reg);
        step_ok  = !too_big_reg && (value_reg != 14'd0) && (value_reg <= {8'd0, size});
        num_ok   = !too_big_reg && (value_reg >= {8'd0, lo}) && (value_reg <= {8'd0, hi});
        finish   = inside_reg && (cmd.take_end || (cmd.take_byte && is_space));

        stat.start_expand = finish && field_ok && (form_reg == cep_pkg::FORM_STEP) && step_ok;
        v_sum             = {1'b0, v_reg} + {1'b0, step_reg};
        stat.expand_last  = v_sum > {1'b0, cep_pkg::field_high(xfield_reg)};

        token_count_next = token_count_reg;
        inside_next      = inside_reg;
        form_next        = form_reg;
        value_next       = value_reg;
        too_big_next     = too_big_reg;
        first_error_next = first_error_reg;
        minute_set_next  = minute_set_reg;
        hour_set_next    = hour_set_reg;
        day_set_next     = day_set_reg;
        month_set_next   = month_set_reg;
        weekday_set_next = weekday_set_reg;
        v_next           = v_reg;
        step_next        = step_reg;
        xfield_next      = xfield_reg;
        res_next         = res_reg;
        set_bits         = '0;
        set_field        = token_count_reg;
        set_en           = 1'b0;

        if (cmd.take_byte && !is_space)
        begin
            inside_next = 1'b1;
            unique case (form_reg)
                cep_pkg::FORM_START:
                begin
                    if (req.character == 8'h2A)
                        form_next = cep_pkg::FORM_STAR;
                    else if (is_digit)
                    begin
                        form_next    = cep_pkg::FORM_NUMBER;
                        value_next   = dig_value;
                        too_big_next = dig_big;
                    end
                    else
                        form_next = cep_pkg::FORM_BAD;
                end
                cep_pkg::FORM_STAR:
                begin
                    form_next = (req.character == 8'h2F) ? cep_pkg::FORM_SLASH
                                                         : cep_pkg::FORM_BAD;
                end
                cep_pkg::FORM_SLASH, cep_pkg::FORM_STEP:
                begin
                    if (is_digit)
                    begin
                        form_next    = cep_pkg::FORM_STEP;
                        value_next   = dig_value;
                        too_big_next = dig_big;
                    end
                    else
                        form_next = cep_pkg::FORM_BAD;
                end
                cep_pkg::FORM_NUMBER:
                begin
                    if (is_digit)
                    begin
                        value_next   = dig_value;
                        too_big_next = dig_big;
                    end
                    else
                        form_next = cep_pkg::FORM_BAD;
                end
                default:
                begin
                    form_next = cep_pkg::FORM_BAD;
                end
            endcase
        end

        if (finish)
        begin
            if (field_ok)
            begin
                unique case (form_reg)
                    cep_pkg::FORM_STAR:
                    begin
                        set_bits = cep_pkg::star_mask(token_count_reg);
                        set_en   = 1'b1;
                    end
                    cep_pkg::FORM_STEP:
                    begin
                        if (too_big_reg)
                        begin
                            if (first_error_reg == cep_pkg::ST_OK)
                                first_error_next = cep_pkg::ST_VALUE;
                        end
                        else if (!step_ok)
                        begin
                            if (first_error_reg == cep_pkg::ST_OK)
                                first_error_next = cep_pkg::ST_STEP;
                        end
                        v_next      = lo;
                        step_next   = value_reg[5:0];
                        xfield_next = token_count_reg;
                    end
                    cep_pkg::FORM_NUMBER:
                    begin
                        if (!num_ok)
                        begin
                            if (first_error_reg == cep_pkg::ST_OK)
                                first_error_next = cep_pkg::ST_VALUE;
                        end
                        else
                        begin
                            set_bits[value_reg[5:0]] = 1'b1;
                            set_en                   = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (first_error_reg == cep_pkg::ST_OK)
                            first_error_next = cep_pkg::ST_SYNTAX;
                    end
                endcase
            end
            if (token_count_reg < cep_pkg::COUNT_SAT)
                token_count_next = token_count_reg + 3'd1;
            inside_next  = 1'b0;
            form_next    = cep_pkg::FORM_START;
            value_next   = '0;
            too_big_next = 1'b0;
        end

        if (cmd.expand)
        begin
            set_bits        = '0;
            set_bits[v_reg] = 1'b1;
            set_field       = xfield_reg;
            set_en          = 1'b1;
            v_next          = v_sum[5:0];
        end

        if (set_en)
        begin
            unique case (set_field)
                cep_pkg::FLD_MINUTE: minute_set_next  = minute_set_reg  | set_bits;
                cep_pkg::FLD_HOUR:   hour_set_next    = hour_set_reg    | set_bits[23:0];
                cep_pkg::FLD_DAY:    day_set_next     = day_set_reg     | set_bits[31:0];
                cep_pkg::FLD_MONTH:  month_set_next   = month_set_reg   | set_bits[12:0];
                default:             weekday_set_next = weekday_set_reg | set_bits[6:0];
            endcase
        end

        status = (token_count_reg != cep_pkg::NUM_FIELDS) ? cep_pkg::ST_COUNT
                                                           : first_error_reg;
        ok     = (status == cep_pkg::ST_OK);

        if (cmd.emit)
        begin
            res_next.status       = status;
            res_next.minute_mask  = ok ? minute_set_reg  : '0;
            res_next.hour_mask    = ok ? hour_set_reg    : '0;
            res_next.day_mask     = ok ? day_set_reg     : '0;
            res_next.month_mask   = ok ? month_set_reg   : '0;
            res_next.weekday_mask = ok ? weekday_set_reg : '0;
            token_count_next = '0;
            inside_next      = 1'b0;
            form_next        = cep_pkg::FORM_START;
            value_next       = '0;
            too_big_next     = 1'b0;
            first_error_next = cep_pkg::ST_OK;
            minute_set_next  = '0;
            hour_set_next    = '0;
            day_set_next     = '0;
            month_set_next   = '0;
            weekday_set_next = '0;
        end
    end

    assign res = res_reg;

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        token_count_reg <= cep_pkg::COUNT_SAT)
        else $error("token count beyond saturation");

    a_expand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.expand |-> (v_reg <= cep_pkg::field_high(xfield_reg)) && (step_reg != 6'd0))
        else $error("step expansion outside field range");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (token_count_reg == 3'd0) && !inside_reg &&
                     (first_error_reg == cep_pkg::ST_OK))
        else $error("state not cleared after result");

endmodule

/* rtl/core/cron_expression_parser.sv */
// Top level of the five-field cron expression parser.
// Byte request: a token ending in a valid step form then sets each value of its step (up to 60),
// the datapath setting one mask bit a cycle.
// End request: result loaded in the EMIT state, after expansion of any open step token.
// A byte request is taken while a result waits; an end request waits for the result slot.
// rst_n is asynchronous active low and clears parser state; the next expression starts clean.
module cron_expression_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cep_pkg::req_t  req,
    output logic           res_valid,
    input  logic           res_ready,
    output cep_pkg::res_t  res
);

    cep_pkg::ctrl_cmd_t cmd;
    cep_pkg::dp_stat_t  stat;

    cep_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_command (req.command),
        .req_ready   (req_ready),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    cep_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .res   (res)
    );

endmodule
